FILE: hw/rtl/morton_tiled_texture_address_gen_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Morton tiled texture address generator
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MORTON_TILED_TEXTURE_ADDRESS_GEN_MACROS_SVH
`define MORTON_TILED_TEXTURE_ADDRESS_GEN_MACROS_SVH

// expr must never be true
`define MTTA_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// cons holds in the same cycle as ante
`define MTTA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define MTTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mtta_pkg.sv
// ---------------------------------------------------------------------------
// mtta_pkg
// Types and constants shared by the Morton tiled address generator.
// ---------------------------------------------------------------------------
package mtta_pkg;

  localparam int TEXEL_W    = 32;
  localparam int OFFSET_W   = 22;
  localparam int DIM_W      = 11;
  localparam int START_W    = 10;
  localparam int BPT_W      = 3;
  localparam int COORD_W    = 11;
  localparam int MORTON_W   = 6;
  localparam int TILE_SIZE  = 8;
  localparam int TILE_SHIFT = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COORD_W-1:0] COARSE_MASK = ~COORD_W'(TILE_SIZE - 1);

  localparam logic [MORTON_W-1:0] MORTON_X [TILE_SIZE] = '{
    6'h00, 6'h01, 6'h04, 6'h05, 6'h10, 6'h11, 6'h14, 6'h15
  };
  localparam logic [MORTON_W-1:0] MORTON_Y [TILE_SIZE] = '{
    6'h00, 6'h02, 6'h08, 6'h0a, 6'h20, 6'h22, 6'h28, 6'h2a
  };

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_START         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_START         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_TEXEL = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0]   tex_width;
    logic [DIM_W-1:0]   tex_height;
    logic [START_W-1:0] x_start;
    logic [START_W-1:0] y_start;
    logic [DIM_W-1:0]   region_width;
    logic [DIM_W-1:0]   region_height;
    logic [BPT_W-1:0]   bytes_per_texel;
  } cfg_t;

  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
  } in_payload_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [TEXEL_W-1:0]  texel_out;
    logic                outside;
    logic                last;
  } out_payload_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] fy;
    logic               outside;
    logic               last;
    logic [TEXEL_W-1:0] texel;
  } queue_entry_t;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } q_status_t;

endpackage

FILE: hw/rtl/mtta_stream_if.sv
// ---------------------------------------------------------------------------
// mtta_stream_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface mtta_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: hw/rtl/morton_tiled_texture_address_gen.sv
// Path: texels pass the two-entry queue, then the two back end stages a and b, to out_s.
// Throughput: one texel per cycle while out_s.ready is high.
// A stalled result channel fills the queue, then holds in_s.ready low.
// Reset: column and row return to zero, registers to their defaults, pipeline empty.
// ---------------------------------------------------------------------------
// morton_tiled_texture_address_gen
// Byte offsets into a vertically flipped 8x8 Morton tiled texture, per texel.
// ---------------------------------------------------------------------------
module morton_tiled_texture_address_gen #(
  parameter int MAX_DIM = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mtta_stream_if.sink                       in_s,
  mtta_stream_if.source                     out_s,
  input  logic                              cfg_we,
  input  logic [mtta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtta_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  mtta_pkg::cfg_t         cfg_r, cfg_nxt;
  mtta_pkg::q_status_t    q_stat;
  mtta_pkg::queue_entry_t q_push_data, q_pop_data;
  logic                   q_push, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mtta_pkg::CFG_TEX_WIDTH:       cfg_nxt.tex_width       = cfg_wdata;
        mtta_pkg::CFG_TEX_HEIGHT:      cfg_nxt.tex_height      = cfg_wdata;
        mtta_pkg::CFG_X_START:         cfg_nxt.x_start         = cfg_wdata[mtta_pkg::START_W-1:0];
        mtta_pkg::CFG_Y_START:         cfg_nxt.y_start         = cfg_wdata[mtta_pkg::START_W-1:0];
        mtta_pkg::CFG_REGION_WIDTH:    cfg_nxt.region_width    = cfg_wdata;
        mtta_pkg::CFG_REGION_HEIGHT:   cfg_nxt.region_height   = cfg_wdata;
        mtta_pkg::CFG_BYTES_PER_TEXEL: cfg_nxt.bytes_per_texel = cfg_wdata[mtta_pkg::BPT_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tex_width       <= mtta_pkg::DIM_W'(8);
      cfg_r.tex_height      <= mtta_pkg::DIM_W'(8);
      cfg_r.x_start         <= '0;
      cfg_r.y_start         <= '0;
      cfg_r.region_width    <= mtta_pkg::DIM_W'(1);
      cfg_r.region_height   <= mtta_pkg::DIM_W'(1);
      cfg_r.bytes_per_texel <= mtta_pkg::BPT_W'(4);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mtta_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_s),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  mtta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  mtta_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_data (q_pop_data),
    .q_pop  (q_pop),
    .out_s  (out_s)
  );

endmodule

FILE: hw/rtl/mtta_front.sv
// ---------------------------------------------------------------------------
// mtta_front
// Accepts texels, tracks column and row, classifies position and end of region.
// ---------------------------------------------------------------------------
`include "morton_tiled_texture_address_gen_macros.svh"

module mtta_front #(
  parameter int MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mtta_stream_if.sink           in_s,
  input  mtta_pkg::cfg_t        cfg,
  input  mtta_pkg::q_status_t   q_stat,
  output logic                  q_push,
  output mtta_pkg::queue_entry_t q_data
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int XW   = ((CW > mtta_pkg::START_W) ? CW : mtta_pkg::START_W) + 1;
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int LW   = (DIMW > mtta_pkg::DIM_W) ? DIMW : mtta_pkg::DIM_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [XW-1:0] x_pos, y_pos;
  logic [LW-1:0] w_lim, h_lim;
  logic          outside, last_col, last_row;

  assign in_s.ready = q_stat.can_push;
  assign q_push     = in_s.valid && in_s.ready;

  always_comb begin
    if (cfg.region_width == '0) begin
      w_lim = LW'(1);
    end else if (LW'(cfg.region_width) > LW'(MAX_DIM)) begin
      w_lim = LW'(MAX_DIM);
    end else begin
      w_lim = LW'(cfg.region_width);
    end
    if (cfg.region_height == '0) begin
      h_lim = LW'(1);
    end else if (LW'(cfg.region_height) > LW'(MAX_DIM)) begin
      h_lim = LW'(MAX_DIM);
    end else begin
      h_lim = LW'(cfg.region_height);
    end
  end

  assign x_pos    = XW'(cfg.x_start) + XW'(col_r);
  assign y_pos    = XW'(cfg.y_start) + XW'(row_r);
  assign outside  = (x_pos >= XW'(cfg.tex_width)) || (y_pos >= XW'(cfg.tex_height));
  assign last_col = (LW'(col_r) + LW'(1)) >= w_lim;
  assign last_row = (LW'(row_r) + LW'(1)) >= h_lim;

  always_comb begin
    q_data.x       = x_pos[mtta_pkg::COORD_W-1:0];
    q_data.fy      = cfg.tex_height - mtta_pkg::COORD_W'(1) - y_pos[mtta_pkg::COORD_W-1:0];
    q_data.outside = outside;
    q_data.last    = last_col && last_row;
    q_data.texel   = in_s.data.texel;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (q_push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  `MTTA_ASSERT_NEXT(a_region_wrap, q_push && last_col && last_row, col_r == '0 && row_r == '0, "counters not cleared after last texel")
  `MTTA_ASSERT_NEXT(a_col_step, q_push && !last_col, col_r == $past(col_r) + CW'(1), "column did not advance")

endmodule

FILE: hw/rtl/mtta_queue.sv
// ---------------------------------------------------------------------------
// mtta_queue
// Short FIFO between the classifying front and the address back end.
// ---------------------------------------------------------------------------
`include "morton_tiled_texture_address_gen_macros.svh"

module mtta_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  mtta_pkg::queue_entry_t push_data,
  input  logic                   pop,
  output mtta_pkg::queue_entry_t pop_data,
  output mtta_pkg::q_status_t    stat
);

  mtta_pkg::queue_entry_t            mem_r [mtta_pkg::QUEUE_DEPTH];
  logic [mtta_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [mtta_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [mtta_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign stat.can_push = count_r != mtta_pkg::QCNT_W'(mtta_pkg::QUEUE_DEPTH);
  assign stat.has_data = count_r != '0;
  assign pop_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + mtta_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + mtta_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + mtta_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - mtta_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `MTTA_ASSERT_NEVER(a_no_overflow, push && !stat.can_push, "push into full queue")
  `MTTA_ASSERT_NEVER(a_no_underflow, pop && !stat.has_data, "pop from empty queue")

endmodule

FILE: hw/rtl/mtta_back.sv
// ---------------------------------------------------------------------------
// mtta_back
// Two-stage tiled index and byte offset pipeline feeding the result channel.
// ---------------------------------------------------------------------------
`include "morton_tiled_texture_address_gen_macros.svh"

module mtta_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mtta_pkg::cfg_t         cfg,
  input  mtta_pkg::q_status_t    q_stat,
  input  mtta_pkg::queue_entry_t q_data,
  output logic                   q_pop,
  mtta_stream_if.source          out_s
);

  logic                          a_valid_r;
  logic [mtta_pkg::OFFSET_W-1:0] a_idx_r;
  logic                          a_outside_r;
  logic                          a_last_r;
  logic [mtta_pkg::TEXEL_W-1:0]  a_texel_r;
  logic                          b_valid_r;
  mtta_pkg::out_payload_t        b_data_r;

  logic                          adv_a, adv_b;
  logic [mtta_pkg::COORD_W-1:0]  cx, cy;
  logic [mtta_pkg::OFFSET_W-1:0] fine, row_term, idx;
  logic [mtta_pkg::OFFSET_W-1:0] offset;

  assign adv_b = !b_valid_r || out_s.ready;
  assign adv_a = !a_valid_r || adv_b;
  assign q_pop = q_stat.has_data && adv_a;

  assign cx       = q_data.x & mtta_pkg::COARSE_MASK;
  assign cy       = q_data.fy & mtta_pkg::COARSE_MASK;
  assign fine     = mtta_pkg::OFFSET_W'(mtta_pkg::MORTON_X[q_data.x[mtta_pkg::TILE_SHIFT-1:0]])
                  + mtta_pkg::OFFSET_W'(mtta_pkg::MORTON_Y[q_data.fy[mtta_pkg::TILE_SHIFT-1:0]]);
  assign row_term = mtta_pkg::OFFSET_W'(cy) * mtta_pkg::OFFSET_W'(cfg.tex_width);
  assign idx      = fine + (mtta_pkg::OFFSET_W'(cx) << mtta_pkg::TILE_SHIFT) + row_term;
  assign offset   = a_idx_r * mtta_pkg::OFFSET_W'(cfg.bytes_per_texel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (adv_a) begin
        a_valid_r <= q_pop;
      end
      if (adv_b) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_idx_r     <= idx;
      a_outside_r <= q_data.outside;
      a_last_r    <= q_data.last;
      a_texel_r   <= q_data.texel;
    end
    if (adv_b && a_valid_r) begin
      b_data_r.byte_offset <= a_outside_r ? '0 : offset;
      b_data_r.texel_out   <= a_texel_r;
      b_data_r.outside     <= a_outside_r;
      b_data_r.last        <= a_last_r;
    end
  end

  assign out_s.valid = b_valid_r;
  assign out_s.data  = b_data_r;

  `MTTA_ASSERT_NEXT(a_stage_hold, a_valid_r && !adv_b, a_valid_r && $stable(a_idx_r), "stalled stage lost its index")
  `MTTA_ASSERT_IMP(a_outside_zero, out_s.valid && out_s.data.outside, out_s.data.byte_offset == '0, "outside texel with nonzero offset")

endmodule
